// ===== hdl/irbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// irbmc_pkg
// Types and constants for the bi-phase infrared remote motor controller.
// ----------------------------------------------------------------------------
package irbmc_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SILENCE_TICKS      = 3'd0,
		REG_SAMPLE_DELAY_TICKS = 3'd1,
		REG_DUTY_LEVEL_ONE     = 3'd2,
		REG_DUTY_LEVEL_TWO     = 3'd3,
		REG_DUTY_LEVEL_THREE   = 3'd4,
		REG_DUTY_LEVEL_FOUR    = 3'd5
	} reg_index_t;

	localparam logic [7:0] SILENCE_TICKS_RST      = 8'd49;
	localparam logic [7:0] SAMPLE_DELAY_TICKS_RST = 8'd16;
	localparam logic [7:0] DUTY_LEVEL_ONE_RST     = 8'd5;
	localparam logic [7:0] DUTY_LEVEL_TWO_RST     = 8'd90;
	localparam logic [7:0] DUTY_LEVEL_THREE_RST   = 8'd180;
	localparam logic [7:0] DUTY_LEVEL_FOUR_RST    = 8'd250;

	localparam logic [7:0] TICK_MAX = 8'd255;

	// remote command codes
	localparam logic [5:0] CMD_DUTY_ONE   = 6'd1;
	localparam logic [5:0] CMD_DUTY_TWO   = 6'd2;
	localparam logic [5:0] CMD_DUTY_THREE = 6'd3;
	localparam logic [5:0] CMD_DUTY_FOUR  = 6'd4;
	localparam logic [5:0] CMD_DIR_A      = 6'd16;
	localparam logic [5:0] CMD_DIR_B      = 6'd17;
	localparam logic [5:0] CMD_DIR_C      = 6'd32;
	localparam logic [5:0] CMD_DIR_D      = 6'd33;
	localparam logic [5:0] CMD_STOP       = 6'd59;

	// direction flag patterns
	localparam logic [3:0] DIR_A    = 4'h6;
	localparam logic [3:0] DIR_B    = 4'h9;
	localparam logic [3:0] DIR_C    = 4'hA;
	localparam logic [3:0] DIR_D    = 4'h5;
	localparam logic [3:0] DIR_NONE = 4'h0;

	localparam logic [3:0] PINS_ALL   = 4'hF;
	localparam logic [3:0] MOTOR_A_MASK = 4'hC;
	localparam logic [3:0] MOTOR_B_MASK = 4'h3;

	typedef enum logic [4:0] {
		ST_SEARCH_ARM   = 5'b00001,
		ST_SEARCH_QUIET = 5'b00010,
		ST_SEARCH_EDGE  = 5'b00100,
		ST_READ_EDGE    = 5'b01000,
		ST_READ_SAMPLE  = 5'b10000
	} dec_state_t;

	typedef struct packed {
		logic [3:0] motor_pins;
		logic       frame_done;
		logic [5:0] command;
	} result_t;

endpackage

// ===== hdl/ir_biphase_remote_motor_control.sv =====
// ----------------------------------------------------------------------------
// ir_biphase_remote_motor_control
// Bi-phase infrared remote decoder steering two motors through an 8-bit PWM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  tick      in         tick_valid/tick_stall   ir_level
//  result    out        result_valid/result_stall  motor_pins, frame_done, command
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  one tick per clock cycle while tick_stall is low; the decoder and PWM state
//  update in the cycle a tick is taken, and the output stage registers its result.
//  a two-entry output stage (result register plus skid register) sets the
//  rate: tick_stall rises only while the skid register holds a result.
//  arst_n restores configuration and all registers but result data to defaults.
// ----------------------------------------------------------------------------
module ir_biphase_remote_motor_control (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	output logic                           tick_stall,
	input  logic                           ir_level,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [3:0]                     motor_pins,
	output logic                           frame_done,
	output logic [5:0]                     command,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [irbmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import irbmc_pkg::*;

	logic [7:0] silence_q, sample_delay_q, level_one_q, level_two_q;
	logic [7:0] level_three_q, level_four_q;

	logic [7:0] tick_q, pwm_q, shift_q, duty_a_q, duty_b_q;
	logic       last_q;
	logic [3:0] dir_q, pins_q;
	dec_state_t state_q;

	logic [7:0] tick_d, pwm_d, shift_d, duty_a_d, duty_b_d, tick_inc;
	logic       last_d, bit_d, done_d;
	logic [3:0] dir_d, pins_d;
	logic [5:0] code_d, cmd_d;
	dec_state_t state_d;

	result_t res_d, out_q, skid_q;
	logic    out_valid_q, skid_valid_q, acc, out_fire;

	assign cfg_ready  = 1'b1;
	assign tick_stall = skid_valid_q;
	assign acc        = tick_valid && !skid_valid_q;
	assign out_fire   = out_valid_q && !result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q      <= SILENCE_TICKS_RST;
			sample_delay_q <= SAMPLE_DELAY_TICKS_RST;
			level_one_q    <= DUTY_LEVEL_ONE_RST;
			level_two_q    <= DUTY_LEVEL_TWO_RST;
			level_three_q  <= DUTY_LEVEL_THREE_RST;
			level_four_q   <= DUTY_LEVEL_FOUR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SILENCE_TICKS:      silence_q      <= cfg_data;
				REG_SAMPLE_DELAY_TICKS: sample_delay_q <= cfg_data;
				REG_DUTY_LEVEL_ONE:     level_one_q    <= cfg_data;
				REG_DUTY_LEVEL_TWO:     level_two_q    <= cfg_data;
				REG_DUTY_LEVEL_THREE:   level_three_q  <= cfg_data;
				REG_DUTY_LEVEL_FOUR:    level_four_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pwm update
	always_comb begin
		bit_d    = ~ir_level;
		tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 8'd1;
		pwm_d    = pwm_q + 8'd1;
		pins_d   = (pwm_d == 8'd0) ? PINS_ALL : pins_q;
		if (pwm_d == duty_a_q)
			pins_d = pins_d & ~(dir_q & MOTOR_A_MASK);
		if (pwm_d == duty_b_q)
			pins_d = pins_d & ~(dir_q & MOTOR_B_MASK);
	end

	// frame decoder
	always_comb begin
		tick_d   = tick_inc;
		state_d  = state_q;
		last_d   = last_q;
		shift_d  = shift_q;
		dir_d    = dir_q;
		duty_a_d = duty_a_q;
		duty_b_d = duty_b_q;
		done_d   = 1'b0;
		code_d   = ~shift_q[6:1];
		cmd_d    = 6'd0;
		unique case (state_q)
			ST_SEARCH_ARM: begin
				tick_d  = 8'd0;
				state_d = ST_SEARCH_QUIET;
				last_d  = bit_d;
			end
			ST_SEARCH_QUIET: begin
				if (bit_d != last_q)
					state_d = ST_SEARCH_ARM;
				else if (tick_inc > silence_q)
					state_d = ST_SEARCH_EDGE;
			end
			ST_SEARCH_EDGE: begin
				if (bit_d != last_q) begin
					state_d = ST_READ_SAMPLE;
					tick_d  = 8'd0;
					shift_d = 8'd0;
				end
			end
			ST_READ_EDGE: begin
				if (bit_d != last_q) begin
					last_d  = bit_d;
					state_d = ST_READ_SAMPLE;
					tick_d  = 8'd0;
				end else if (tick_inc > silence_q) begin
					done_d  = 1'b1;
					cmd_d   = code_d;
					state_d = ST_SEARCH_ARM;
					case (code_d)
						CMD_DIR_B: dir_d = DIR_B;
						CMD_DIR_A: dir_d = DIR_A;
						CMD_DIR_C: dir_d = DIR_C;
						CMD_DIR_D: dir_d = DIR_D;
						CMD_STOP:  dir_d = DIR_NONE;
						CMD_DUTY_ONE: begin
							duty_a_d = level_one_q;
							duty_b_d = level_one_q;
						end
						CMD_DUTY_TWO: begin
							duty_a_d = level_two_q;
							duty_b_d = level_two_q;
						end
						CMD_DUTY_THREE: begin
							duty_a_d = level_three_q;
							duty_b_d = level_three_q;
						end
						CMD_DUTY_FOUR: begin
							duty_a_d = level_four_q;
							duty_b_d = level_four_q;
						end
						default: ;
					endcase
				end
			end
			ST_READ_SAMPLE: begin
				if (tick_inc > sample_delay_q) begin
					state_d = ST_READ_EDGE;
					last_d  = bit_d;
					shift_d = {shift_q[6:0], bit_d};
				end
			end
			default: state_d = ST_SEARCH_ARM;
		endcase
		res_d = '{motor_pins: pins_d, frame_done: done_d, command: cmd_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= 8'd0;
			pwm_q    <= 8'd0;
			state_q  <= ST_SEARCH_ARM;
			last_q   <= 1'b0;
			shift_q  <= 8'd0;
			dir_q    <= DIR_NONE;
			duty_a_q <= 8'd0;
			duty_b_q <= 8'd0;
			pins_q   <= PINS_ALL;
		end else if (acc) begin
			tick_q   <= tick_d;
			pwm_q    <= pwm_d;
			state_q  <= state_d;
			last_q   <= last_d;
			shift_q  <= shift_d;
			dir_q    <= dir_d;
			duty_a_q <= duty_a_d;
			duty_b_q <= duty_b_d;
			pins_q   <= pins_d;
		end
	end

	// output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			if (!out_valid_q || out_fire)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_fire) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (!out_valid_q || out_fire)
				out_q <= res_d;
			else
				skid_q <= res_d;
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result_valid = out_valid_q;
	assign motor_pins   = out_q.motor_pins;
	assign frame_done   = out_q.frame_done;
	assign command      = out_q.command;

	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while output register is empty");

	a_accept_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q)
		else $error("accepted tick produced no pending result");

	a_frame_end_rearms : assert property (@(posedge clk) disable iff (!arst_n)
		(acc && done_d) |=> (state_q == ST_SEARCH_ARM))
		else $error("decoder did not rearm the search after frame end");

endmodule
